// ----- rtl/core/ssc_pkg.sv -----
// shared types and constants for the sphere contact pipeline
// no dependencies
package ssc_pkg;

  localparam int PosW   = 32;
  localparam int RadW   = 31;
  localparam int MagW   = 33;
  localparam int SqW    = 66;
  localparam int SumW   = 66;
  localparam int RootW  = 34;
  localparam int RremW  = 68;
  localparam int NormFrac = 16;
  localparam int QW     = NormFrac + 1;
  localparam int NremW  = 100;
  localparam int NqsW   = 84;
  localparam int CombW  = 32;
  localparam int NormW  = 18;
  localparam int HalfW  = 34;
  localparam int InW    = 256;
  localparam int OutW   = 96;
  localparam int RootStages = RootW;

  // payload carried through the root / normal stages
  typedef struct packed {
    logic [RremW-1:0]         rrem;
    logic [RootW-1:0]         root;
    logic [2:0][NremW-1:0]    nrem;
    logic [2:0][NqsW-1:0]     nqs;
    logic [2:0][QW-1:0]       q;
    logic [2:0]               neg;
    logic [SumW-1:0]          s;
    logic [CombW-1:0]         comb;
  } ssc_item_t;

endpackage

// ----- rtl/core/sphere_sphere_contact_core.sv -----
// sphere contact pipeline top level: front end, root stages, output register
// depends on ssc_pkg, ssc_front, ssc_root_stage
//
//  channel  | dir | word
//  s_axis   | in  | two centres and two radii, one pair per word
//  m_axis   | out | contact flag, unit normal, half depth, degenerate flag
//
// a pair enters every cycle while the output is not stalled; 3 front stages,
// 34 root stages and an output register, set by the one-bit-per-stage root
// rst clears all valid bits; payload registers are not reset
// the whole pipe holds while a result waits in the output register
module sphere_sphere_contact_core import ssc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // a_pos_x, a_pos_y, a_pos_z, b_pos_x, b_pos_y, b_pos_z (32 each),
  // a_radius, b_radius (31 each), 2 zero bits
  input  logic [InW-1:0]   s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // colliding (1), normal_x, normal_y, normal_z (18 each), half_depth (34),
  // degenerate (1), 6 zero bits
  output logic [OutW-1:0]  m_axis_tdata
);

  logic       en;
  logic       v [RootStages+1];
  ssc_item_t  it [RootStages+1];

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  ssc_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_axis_tvalid && en), .in_data(s_axis_tdata),
    .out_valid(v[0]), .out_item(it[0])
  );

  // root and normal stages
  for (genvar k = 0; k < RootStages; k++) begin : g_root
    ssc_root_stage #(.STAGE(k)) u_stage (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(v[k]), .in_item(it[k]),
      .out_valid(v[k+1]), .out_item(it[k+1])
    );
  end

  ssc_item_t               fin;
  logic                    degen;
  logic signed [HalfW:0]   diff;
  logic [2:0][NormW-1:0]   nrm;
  logic [OutW-1:0]         data_next;

  // result forming
  always_comb begin
    fin   = it[RootStages];
    degen = (fin.s == '0);
    diff  = signed'((HalfW+1)'(fin.comb)) - signed'((HalfW+1)'(fin.root));
    for (int i = 0; i < 3; i++) begin
      nrm[i] = degen ? '0 :
               (fin.neg[i] ? NormW'(-NormW'(fin.q[i])) : NormW'(fin.q[i]));
    end
    data_next = '0;
    data_next[0]      = (RootW+1)'(fin.root) < (RootW+1)'(fin.comb);
    data_next[18:1]   = nrm[0];
    data_next[36:19]  = nrm[1];
    data_next[54:37]  = nrm[2];
    data_next[88:55]  = HalfW'(diff >>> 1);
    data_next[89]     = degen;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= v[RootStages];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= data_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_degen_zero_normal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[89] |-> m_axis_tdata[54:1] == '0)
    else $error("degenerate result with nonzero normal");
  a_collide_depth: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[88])
    else $error("contact with negative half depth");
  a_apart_depth: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[88] || m_axis_tdata[88:55] == '0)
    else $error("no contact but positive half depth");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pipe moved while output stalled");
`endif

endmodule

// ----- rtl/core/ssc_front.sv -----
// offset, magnitude, squares and sum of squares, three register stages
// depends on ssc_pkg
module ssc_front import ssc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [InW-1:0]    in_data,
  output logic              out_valid,
  output ssc_item_t         out_item
);

  logic [2:0]              v;
  logic [2:0][MagW-1:0]    m1;
  logic [2:0]              neg1, neg2;
  logic [CombW-1:0]        comb1, comb2;
  logic [2:0][SqW-1:0]     sq2;
  logic [2:0][MagW-1:0]    m_next;
  logic [2:0]              neg_next;
  logic signed [MagW-1:0]  d [3];

  // offsets and magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = MagW'(signed'(in_data[(i+3)*PosW +: PosW]))
           - MagW'(signed'(in_data[i*PosW +: PosW]));
      neg_next[i] = d[i][MagW-1];
      m_next[i] = neg_next[i] ? MagW'(-d[i]) : MagW'(d[i]);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], in_valid};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      m1    <= m_next;
      neg1  <= neg_next;
      comb1 <= CombW'(in_data[6*PosW +: RadW]) + CombW'(in_data[6*PosW+RadW +: RadW]);
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= SqW'(m1[i]) * SqW'(m1[i]);
      end
      neg2  <= neg1;
      comb2 <= comb1;
      out_item.s    <= sq2[0] + sq2[1] + sq2[2];
      out_item.rrem <= RremW'(sq2[0] + sq2[1] + sq2[2]);
      out_item.root <= '0;
      for (int i = 0; i < 3; i++) begin
        out_item.nrem[i] <= NremW'(sq2[i]) << (2 * NormFrac);
        out_item.nqs[i]  <= '0;
        out_item.q[i]    <= '0;
      end
      out_item.neg  <= neg2;
      out_item.comb <= comb2;
    end
  end

  assign out_valid = v[2];

endmodule

// ----- rtl/core/ssc_root_stage.sv -----
// one bit of the square root and, in the early stages, one bit of each normal
// depends on ssc_pkg
module ssc_root_stage import ssc_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  ssc_item_t  in_item,
  output logic       out_valid,
  output ssc_item_t  out_item
);

  localparam int B  = RootW - 1 - STAGE;
  localparam int NB = NormFrac - STAGE;

  ssc_item_t          item_next;
  logic [RremW-1:0]   trial;
  logic [2:0][NremW-1:0] ntrial;

  // restoring root step, plus restoring normal step while bits remain
  always_comb begin
    item_next = in_item;
    trial = (RremW'(in_item.root) << (B + 1)) | (RremW'(1) << (2 * B));
    if (in_item.rrem >= trial) begin
      item_next.rrem = in_item.rrem - trial;
      item_next.root = in_item.root | (RootW'(1) << B);
    end
    for (int i = 0; i < 3; i++) begin
      ntrial[i] = '0;
      if (NB >= 0) begin
        ntrial[i] = (NremW'(in_item.nqs[i]) << (NB + 1))
                  + (NremW'(in_item.s) << (2 * NB));
        if (in_item.nrem[i] >= ntrial[i]) begin
          item_next.nrem[i] = in_item.nrem[i] - ntrial[i];
          item_next.q[i]    = in_item.q[i] | (QW'(1) << NB);
          item_next.nqs[i]  = in_item.nqs[i] + (NqsW'(in_item.s) << NB);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule
